[rtl/sso_pkg.sv]
// Package for the sorted set operation engine.
// Holds opcode codes, controller states and the controller-to-datapath command word.
// No dependencies.
`default_nettype none
package sso_pkg;

   typedef logic [2:0] opcode_type;

   localparam opcode_type OP_LOAD_A    = 3'd0;
   localparam opcode_type OP_LOAD_B    = 3'd1;
   localparam opcode_type OP_INTERSECT = 3'd2;
   localparam opcode_type OP_UNION     = 3'd3;
   localparam opcode_type OP_DIFF      = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SORT_STORE,
      ST_CHECK,
      ST_ACK,
      ST_SORT_WORK,
      ST_MERGE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic       load_wr;
      logic       sort_store;
      logic       check_rep;
      logic       copy_work;
      logic       sort_work;
      logic       odd_pass;
      logic       merge_step;
      logic       ack;
      logic       finish;
      opcode_type op;
   } dp_cmd_type;

endpackage
`default_nettype wire

[rtl/sso_datapath.sv]
// Datapath: set stores, sorted working copies, merge step and result register.
// Depends on sso_pkg; driven by sso_controller through a dp_cmd_type word.
`default_nettype none
module sso_datapath import sso_pkg::*; #(
   parameter int SET_SIZE = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   input  wire logic [2:0]         req_element_index,
   input  wire logic signed [31:0] req_element_value,
   output logic                    merge_done,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_member_value,
   output logic                    rsp_is_member,
   output logic                    rsp_repeat_found,
   output logic                    rsp_last_result
);

   localparam int IW = $clog2(SET_SIZE);
   localparam int CW = $clog2(SET_SIZE + 1);

   typedef logic [SET_SIZE-1:0][31:0] vec_type;

   // One odd-even transposition pass; pairs of one parity are disjoint.
   function automatic vec_type oe_step(input vec_type v, input logic odd);
      vec_type r;
      r = v;
      for (int k = 0; k < SET_SIZE - 1; k++) begin
         if ((k % 2 == 1) == odd && $signed(v[k]) > $signed(v[k+1])) begin
            r[k]   = v[k+1];
            r[k+1] = v[k];
         end
      end
      return r;
   endfunction

   function automatic logic has_repeat(input vec_type v);
      logic f;
      f = 1'b0;
      for (int k = 0; k < SET_SIZE - 1; k++) begin
         f = f | (v[k] == v[k+1]);
      end
      return f;
   endfunction

   vec_type store_a_ff, store_b_ff, work_a_ff, work_b_ff;
   logic [CW-1:0] cnt_a_ff, cnt_b_ff;
   logic rep_a_ff, rep_b_ff;
   logic pend_valid_ff;
   logic [31:0] pend_val_ff;
   logic strobe_ff, is_member_ff, repeat_ff, last_ff;
   logic [31:0] value_ff;

   logic [IW-1:0] wr_idx;
   logic [5:0] idx_wide;
   logic sel_b;
   logic has_a, has_b, a_lt, a_eq;
   logic emit, adv_a, adv_b;
   logic [31:0] emit_val;
   logic op_rep, ack_rep;

   assign idx_wide = {3'b000, req_element_index};
   assign wr_idx   = idx_wide[IW-1:0];
   assign sel_b    = (cmd.op == OP_LOAD_B);
   assign has_a    = (cnt_a_ff != '0);
   assign has_b    = (cnt_b_ff != '0);
   assign a_lt     = $signed(work_a_ff[0]) < $signed(work_b_ff[0]);
   assign a_eq     = (work_a_ff[0] == work_b_ff[0]);
   assign op_rep   = rep_a_ff | rep_b_ff;

   always_comb begin
      case (cmd.op)
         OP_LOAD_A: ack_rep = rep_a_ff;
         OP_LOAD_B: ack_rep = rep_b_ff;
         default:   ack_rep = op_rep;
      endcase
   end

   always_comb begin
      merge_done = 1'b0;
      emit       = 1'b0;
      adv_a      = 1'b0;
      adv_b      = 1'b0;
      emit_val   = work_a_ff[0];
      case (cmd.op)
         OP_INTERSECT: begin
            merge_done = !has_a || !has_b;
            if (a_eq) begin
               emit  = 1'b1;
               adv_a = 1'b1;
               adv_b = 1'b1;
            end else if (a_lt) begin
               adv_a = 1'b1;
            end else begin
               adv_b = 1'b1;
            end
         end
         OP_UNION: begin
            merge_done = !has_a && !has_b;
            emit = 1'b1;
            if (has_a && (!has_b || a_lt)) begin
               adv_a = 1'b1;
            end else if (has_a && has_b && a_eq) begin
               adv_a = 1'b1;
               adv_b = 1'b1;
            end else begin
               adv_b    = 1'b1;
               emit_val = work_b_ff[0];
            end
         end
         default: begin
            merge_done = !has_a;
            if (!has_b || a_lt) begin
               emit  = 1'b1;
               adv_a = 1'b1;
            end else if (a_eq) begin
               adv_a = 1'b1;
            end else begin
               adv_b = 1'b1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         if (sel_b) begin
            store_b_ff[wr_idx] <= req_element_value;
         end else begin
            store_a_ff[wr_idx] <= req_element_value;
         end
      end
      if (cmd.sort_store) begin
         if (sel_b) begin
            store_b_ff <= oe_step(store_b_ff, cmd.odd_pass);
         end else begin
            store_a_ff <= oe_step(store_a_ff, cmd.odd_pass);
         end
      end
      if (cmd.copy_work) begin
         work_a_ff <= store_a_ff;
         work_b_ff <= store_b_ff;
         cnt_a_ff  <= CW'(SET_SIZE);
         cnt_b_ff  <= CW'(SET_SIZE);
      end
      if (cmd.sort_work) begin
         work_a_ff <= oe_step(work_a_ff, cmd.odd_pass);
         work_b_ff <= oe_step(work_b_ff, cmd.odd_pass);
      end
      if (cmd.merge_step) begin
         if (adv_a) begin
            work_a_ff <= work_a_ff >> 32;
            cnt_a_ff  <= cnt_a_ff - 1'b1;
         end
         if (adv_b) begin
            work_b_ff <= work_b_ff >> 32;
            cnt_b_ff  <= cnt_b_ff - 1'b1;
         end
         if (emit) begin
            pend_val_ff <= emit_val;
         end
      end
      value_ff     <= 32'd0;
      is_member_ff <= 1'b0;
      repeat_ff    <= op_rep;
      last_ff      <= 1'b1;
      if (cmd.ack) begin
         repeat_ff <= ack_rep;
      end else if (cmd.merge_step) begin
         value_ff     <= pend_val_ff;
         is_member_ff <= 1'b1;
         last_ff      <= 1'b0;
      end else if (cmd.finish && pend_valid_ff) begin
         value_ff     <= pend_val_ff;
         is_member_ff <= 1'b1;
      end
   end

   // A result is held back one step so that the final one can carry its last mark.
   always_ff @(posedge clock) begin
      if (reset) begin
         rep_a_ff      <= 1'b0;
         rep_b_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         strobe_ff     <= 1'b0;
      end else begin
         if (cmd.check_rep) begin
            if (sel_b) begin
               rep_b_ff <= has_repeat(store_b_ff);
            end else begin
               rep_a_ff <= has_repeat(store_a_ff);
            end
         end
         if (cmd.copy_work || cmd.finish) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.merge_step && emit) begin
            pend_valid_ff <= 1'b1;
         end
         strobe_ff <= cmd.ack || cmd.finish || (cmd.merge_step && emit && pend_valid_ff);
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_member_value = value_ff;
   assign rsp_is_member    = is_member_ff;
   assign rsp_repeat_found = repeat_ff;
   assign rsp_last_result  = last_ff;

endmodule
`default_nettype wire

[rtl/sso_controller.sv]
// Controller state machine: decodes a request and sequences sorts, merge and results.
// Depends on sso_pkg; commands sso_datapath.
`default_nettype none
module sso_controller import sso_pkg::*; #(
   parameter int SET_SIZE = 8
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire opcode_type req_opcode,
   input  wire logic [2:0] req_element_index,
   input  wire logic       merge_done,
   output logic            busy,
   output dp_cmd_type      cmd
);

   localparam int PW = $clog2(SET_SIZE);

   state_type state_ff, state_in;
   opcode_type op_ff, op_in;
   logic [PW-1:0] pass_ff, pass_in;
   logic [5:0] idx_wide;
   logic in_range, last_idx, last_pass;

   assign idx_wide  = {3'b000, req_element_index};
   assign in_range  = idx_wide < 6'(SET_SIZE);
   assign last_idx  = idx_wide == 6'(SET_SIZE - 1);
   assign last_pass = pass_ff == PW'(SET_SIZE - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         op_ff    <= OP_LOAD_A;
         pass_ff  <= '0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         pass_ff  <= pass_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      pass_in      = pass_ff;
      cmd          = '0;
      cmd.op       = op_ff;
      cmd.odd_pass = pass_ff[0];
      busy         = (state_ff != ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            cmd.op = req_opcode;
            if (start) begin
               op_in   = req_opcode;
               pass_in = '0;
               case (req_opcode)
                  OP_LOAD_A, OP_LOAD_B: begin
                     cmd.load_wr = in_range;
                     state_in    = last_idx ? ST_SORT_STORE : ST_ACK;
                  end
                  OP_INTERSECT, OP_UNION, OP_DIFF: begin
                     cmd.copy_work = 1'b1;
                     state_in      = ST_SORT_WORK;
                  end
                  default: state_in = ST_ACK;
               endcase
            end
         end
         ST_SORT_STORE: begin
            cmd.sort_store = 1'b1;
            pass_in        = pass_ff + 1'b1;
            if (last_pass) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check_rep = 1'b1;
            state_in      = ST_ACK;
         end
         ST_ACK: begin
            cmd.ack  = 1'b1;
            state_in = ST_IDLE;
         end
         ST_SORT_WORK: begin
            cmd.sort_work = 1'b1;
            pass_in       = pass_ff + 1'b1;
            if (last_pass) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (merge_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.merge_step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

[rtl/sorted_set_operation_engine.sv]
// Sorted set operation engine: top level joining controller and datapath.
// Depends on sso_pkg, sso_controller and sso_datapath.
//
// Usage: a request word is taken when start is high and busy is low. Opcodes
// load A or load B write one element at req_element_index; loading the last
// index sorts that set with SET_SIZE odd-even passes and updates its repeat
// flag. Intersect, union and difference sort copies of both sets and merge
// them, one merge step a cycle.
// Results leave as one word per cycle on the rsp_ ports while rsp_strobe is
// high; the receiver cannot stall, and the final word of a request carries
// rsp_last_result. An empty answer, a load or an unknown opcode gives one
// non-member word. A plain load goes from ST_IDLE to ST_ACK; a sorting load
// passes through ST_SORT_STORE and ST_CHECK before ST_ACK. A set operation
// copies both sets, sorts the copies with SET_SIZE odd-even passes, merges
// them and finishes. One request is in work at a time; busy stays high until
// its last word is launched.
// Reset clears the repeat flags and the controller; set contents stay
// undefined until loaded.
`default_nettype none
module sorted_set_operation_engine import sso_pkg::*; #(
   parameter int SET_SIZE = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [2:0]         req_element_index,
   input  wire logic signed [31:0] req_element_value,
   output logic                    rsp_strobe,
   output logic signed [31:0]      rsp_member_value,
   output logic                    rsp_is_member,
   output logic                    rsp_repeat_found,
   output logic                    rsp_last_result
);

   dp_cmd_type cmd;
   logic merge_done;

   sso_controller #(.SET_SIZE(SET_SIZE)) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .req_opcode        (req_opcode),
      .req_element_index (req_element_index),
      .merge_done        (merge_done),
      .busy              (busy),
      .cmd               (cmd)
   );

   sso_datapath #(.SET_SIZE(SET_SIZE)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_element_index (req_element_index),
      .req_element_value (req_element_value),
      .merge_done        (merge_done),
      .rsp_strobe        (rsp_strobe),
      .rsp_member_value  (rsp_member_value),
      .rsp_is_member     (rsp_is_member),
      .rsp_repeat_found  (rsp_repeat_found),
      .rsp_last_result   (rsp_last_result)
   );

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy did not rise after an accepted word");

   a_nonmember_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_is_member |-> rsp_last_result && rsp_member_value == 32'sd0)
      else $error("non-member word not marked last or not zero");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_result |-> !busy)
      else $error("last word launched while still busy");

endmodule
`default_nettype wire

[tb/tb_sorted_set_operation_engine.sv]
// Testbench for the sorted set operation engine: loads sets A and B, runs
// intersect, union and difference, and checks every result word against a local predictor.
// Depends on sso_pkg and the RTL of sorted_set_operation_engine.
`timescale 1ns / 1ps
module tb_sorted_set_operation_engine import sso_pkg::*;;

   localparam int SET_SIZE = 8;
   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic signed [31:0] member_value;
      logic               is_member;
      logic               repeat_found;
      logic               last_result;
   } set_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [2:0] req_opcode = OP_LOAD_A;
   logic [2:0] req_element_index = '0;
   logic signed [31:0] req_element_value = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_member_value;
   logic rsp_is_member, rsp_repeat_found, rsp_last_result;

   logic signed [31:0] model_a [SET_SIZE];
   logic signed [31:0] model_b [SET_SIZE];
   logic rep_a, rep_b;
   set_word_type expected_words [$];
   int mismatches = 0;
   int cycles = 0;
   bit idle_on = 1'b1;

   sorted_set_operation_engine #(.SET_SIZE(SET_SIZE)) dut (
      .clock, .reset, .start, .busy, .req_opcode, .req_element_index, .req_element_value,
      .rsp_strobe, .rsp_member_value, .rsp_is_member, .rsp_repeat_found, .rsp_last_result
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic sort_set(ref logic signed [31:0] s [SET_SIZE], output logic rep);
      logic signed [31:0] t;
      rep = 1'b0;
      for (int i = 1; i < SET_SIZE; i++)
         for (int j = 0; j < SET_SIZE - i; j++)
            if (s[j] > s[j + 1]) begin
               t = s[j]; s[j] = s[j + 1]; s[j + 1] = t;
            end
      for (int i = 0; i + 1 < SET_SIZE; i++)
         if (s[i] == s[i + 1]) rep = 1'b1;
   endtask

   function automatic set_word_type mk(logic signed [31:0] v, logic m, logic r, logic l);
      set_word_type w;
      w.member_value = v; w.is_member = m; w.repeat_found = r; w.last_result = l;
      return w;
   endfunction

   task automatic predict_set_words(logic [2:0] op, logic [2:0] idx, logic signed [31:0] val);
      logic signed [31:0] a [SET_SIZE];
      logic signed [31:0] b [SET_SIZE];
      logic rep, dummy, ha, hb;
      int i, j, n;
      rep = rep_a | rep_b;
      i = 0; j = 0; n = 0;
      if (op == OP_LOAD_A) begin
         if (idx < SET_SIZE) begin
            model_a[idx] = val;
            if (idx == SET_SIZE - 1) sort_set(model_a, rep_a);
         end
         expected_words.push_back(mk(0, 0, rep_a, 1));
      end else if (op == OP_LOAD_B) begin
         if (idx < SET_SIZE) begin
            model_b[idx] = val;
            if (idx == SET_SIZE - 1) sort_set(model_b, rep_b);
         end
         expected_words.push_back(mk(0, 0, rep_b, 1));
      end else if (op > OP_DIFF) begin
         expected_words.push_back(mk(0, 0, rep, 1));
      end else begin
         a = model_a; b = model_b;
         sort_set(a, dummy); sort_set(b, dummy);
         while (i < SET_SIZE || j < SET_SIZE) begin
            ha = i < SET_SIZE; hb = j < SET_SIZE;
            if (op == OP_INTERSECT) begin
               if (!ha || !hb) break;
               if (a[i] == b[j]) begin
                  expected_words.push_back(mk(a[i], 1, rep, 0)); n++; i++; j++;
               end else if (a[i] < b[j]) i++;
               else j++;
            end else if (op == OP_UNION) begin
               if (ha && (!hb || a[i] < b[j])) begin
                  expected_words.push_back(mk(a[i], 1, rep, 0)); n++; i++;
               end else if (ha && hb && a[i] == b[j]) begin
                  expected_words.push_back(mk(a[i], 1, rep, 0)); n++; i++; j++;
               end else begin
                  expected_words.push_back(mk(b[j], 1, rep, 0)); n++; j++;
               end
            end else begin
               if (!ha) break;
               if (!hb || a[i] < b[j]) begin
                  expected_words.push_back(mk(a[i], 1, rep, 0)); n++; i++;
               end else if (a[i] == b[j]) i++;
               else j++;
            end
         end
         if (n == 0) expected_words.push_back(mk(0, 0, rep, 1));
         else expected_words[$].last_result = 1'b1;
      end
   endtask

   // Result checker: the receiver never stalls, so every strobe is a word.
   always @(posedge clock) begin
      set_word_type e;
      if (!reset && rsp_strobe) begin
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Unexpected result word %0d", rsp_member_value);
         end else begin
            e = expected_words.pop_front();
            if (rsp_member_value !== e.member_value || rsp_is_member !== e.is_member ||
                rsp_repeat_found !== e.repeat_found || rsp_last_result !== e.last_result) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: exp %0d/%b/%b/%b got %0d/%b/%b/%b",
                     e.member_value, e.is_member, e.repeat_found, e.last_result,
                     rsp_member_value, rsp_is_member, rsp_repeat_found, rsp_last_result);
            end
         end
      end
   end

   // Busy comes from a register, so a word offered at a falling edge while busy
   // is low is taken at the next rising edge.
   task automatic send_word(logic [2:0] op, logic [2:0] idx, logic signed [31:0] val);
      while (idle_on && $urandom_range(99) < 24) @(negedge clock);
      while (busy) @(negedge clock);
      start <= 1'b1;
      req_opcode <= op; req_element_index <= idx; req_element_value <= val;
      @(posedge clock);
      predict_set_words(op, idx, val);
      @(negedge clock);
      start <= 1'b0;
   endtask

   task automatic wait_drained;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (4 * SET_SIZE + 10) @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_value(int pool);
      case ($urandom_range(3))
         0: return $urandom_range(pool) - pool / 2;
         1: return $urandom;
         default: return $urandom_range(2) == 0 ? 32'sh7fffffff :
            ($urandom_range(1) ? 32'sh80000000 : $signed($urandom_range(pool)));
      endcase
   endfunction

   task automatic load_set(logic [2:0] op, int pool);
      for (int k = 0; k < SET_SIZE; k++) send_word(op, k[2:0], rand_value(pool));
   endtask

   task automatic test_directed;
      for (int k = 0; k < SET_SIZE; k++) send_word(OP_LOAD_A, k[2:0], 32'sh7fffffff - k);
      for (int k = 0; k < SET_SIZE; k++)
         send_word(OP_LOAD_B, k[2:0], k < 4 ? 32'sh80000000 : 32'sh7fffffff - k);
      send_word(OP_INTERSECT, 3'd7, 32'sh80000000);
      send_word(OP_UNION, 3'd0, 0);
      send_word(OP_DIFF, 3'd0, 0);
      send_word(3'd5, 3'd0, 0);
      send_word(3'd7, 3'd7, -1);
   endtask

   task automatic test_empty_and_unsorted;
      // Disjoint sets give an empty intersection; a late write leaves A unsorted.
      for (int k = 0; k < SET_SIZE; k++) send_word(OP_LOAD_A, k[2:0], k);
      for (int k = 0; k < SET_SIZE; k++) send_word(OP_LOAD_B, k[2:0], k + 100);
      send_word(OP_INTERSECT, 0, 0);
      send_word(OP_LOAD_A, 3'd0, 500);
      send_word(OP_DIFF, 0, 0);
      send_word(OP_UNION, 0, 0);
      wait_drained();
   endtask

   task automatic test_random;
      for (int r = 0; r < 7; r++) begin
         idle_on = (r != 2);
         load_set(OP_LOAD_A, 12);
         load_set(OP_LOAD_B, 12);
         for (int k = 0; k < 4; k++) begin
            if ($urandom_range(3) == 0)
               send_word($urandom_range(1), $urandom_range(7), rand_value(12));
            else
               send_word($urandom_range(OP_INTERSECT, 7), $urandom, $urandom);
         end
         if (r == 3) wait_drained();
      end
      idle_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_empty_and_unsorted();
      test_random();
      wait_drained();
      if (mismatches == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
